// File: design/cvam_pkg.sv
package cvam_pkg;

   // fixed field widths
   localparam int unsigned IN_W    = 24;
   localparam int unsigned OUT_W   = 24;
   localparam int unsigned ANGLE_W = 11;
   localparam int unsigned GAIN_W  = 8;

   // default datapath format
   localparam int unsigned DEFAULT_WIDTH     = 24;
   localparam int unsigned DEFAULT_FRAC_BITS = 8;

   // gain register reset value
   localparam logic [GAIN_W-1:0] GAIN_RESET = 8'd78;

   // each shift is used this many times in a row
   localparam int unsigned REPEATS = 2;

   // arctangent of 2^-i for the first few shifts, 8 fraction bits
   localparam int unsigned ATAN_LUT_LEN = 5;
   localparam logic [ANGLE_W-1:0] ATAN_LUT [ATAN_LUT_LEN] = '{
      11'h0c9, 11'h077, 11'h03f, 11'h020, 11'h010
   };

   // arctangent for a given shift; past the table it is 2^-shift, the small-angle value
   function automatic logic [ANGLE_W-1:0] atan_of(input int unsigned shift,
                                                 input int unsigned frac_bits);
      logic [31:0] one_val;
      logic [31:0] shifted;
      one_val = 32'd1 << frac_bits;
      shifted = one_val >> shift;
      if (shift < ATAN_LUT_LEN) begin
         return ATAN_LUT[shift];
      end
      return shifted[ANGLE_W-1:0];
   endfunction

endpackage

// File: design/cvam_cell.sv
module cvam_cell #(
   parameter int unsigned WIDTH     = 24,
   parameter int unsigned FRAC_BITS = 8,
   parameter int unsigned SHIFT     = 0
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   output logic                               in_ready,
   input  logic signed [WIDTH-1:0]            in_x,
   input  logic signed [WIDTH-1:0]            in_y,
   input  logic [cvam_pkg::ANGLE_W-1:0]       in_angle,
   output logic                               out_valid,
   input  logic                               out_ready,
   output logic signed [WIDTH-1:0]            out_x,
   output logic signed [WIDTH-1:0]            out_y,
   output logic [cvam_pkg::ANGLE_W-1:0]       out_angle
);
   import cvam_pkg::*;

   localparam logic [ANGLE_W-1:0] ATAN_STEP = atan_of(SHIFT, FRAC_BITS);

   logic                      valid_ff, valid_in;
   logic signed [WIDTH-1:0]   x_ff, x_in;
   logic signed [WIDTH-1:0]   y_ff, y_in;
   logic [ANGLE_W-1:0]        angle_ff, angle_in;
   logic                      ccw;
   logic signed [WIDTH-1:0]   dx;
   logic signed [WIDTH-1:0]   dy;
   logic                      load;

   // stage takes a transaction when empty or when its content moves on
   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;

   // one micro-rotation: direction from the sign of y
   assign ccw = in_y[WIDTH-1];
   assign dx  = in_y >>> SHIFT;
   assign dy  = in_x >>> SHIFT;

   always_comb begin
      if (ccw) begin
         x_in     = in_x - dx;
         y_in     = in_y + dy;
         angle_in = in_angle - ATAN_STEP;
      end else begin
         x_in     = in_x + dx;
         y_in     = in_y - dy;
         angle_in = in_angle + ATAN_STEP;
      end
   end

   // valid bit
   always_comb begin
      if (in_ready) begin
         valid_in = in_valid;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (load) begin
         x_ff     <= x_in;
         y_ff     <= y_in;
         angle_ff <= angle_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_angle = angle_ff;

endmodule

// File: design/cvam_scale.sv
module cvam_scale #(
   parameter int unsigned WIDTH     = 24,
   parameter int unsigned FRAC_BITS = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [cvam_pkg::GAIN_W-1:0]        gain,
   input  logic                               in_valid,
   output logic                               in_ready,
   input  logic signed [WIDTH-1:0]            in_x,
   input  logic signed [WIDTH-1:0]            in_y,
   input  logic [cvam_pkg::ANGLE_W-1:0]       in_angle,
   output logic                               out_valid,
   input  logic                               out_ready,
   output logic signed [cvam_pkg::ANGLE_W-1:0] out_angle,
   output logic signed [cvam_pkg::OUT_W-1:0]   out_magnitude,
   output logic signed [cvam_pkg::OUT_W-1:0]   out_residual_y
);
   import cvam_pkg::*;

   localparam int unsigned PROD_W = WIDTH + GAIN_W + 1;

   logic                       valid_ff, valid_in;
   logic [ANGLE_W-1:0]         angle_ff;
   logic signed [OUT_W-1:0]    mag_ff, mag_in;
   logic signed [OUT_W-1:0]    res_ff, res_in;
   logic signed [GAIN_W:0]     gain_s;
   logic signed [PROD_W-1:0]   prod_x;
   logic signed [PROD_W-1:0]   prod_y;
   logic signed [PROD_W-1:0]   sh_x;
   logic signed [PROD_W-1:0]   sh_y;
   logic signed [WIDTH-1:0]   wrap_x;
   logic signed [WIDTH-1:0]   wrap_y;
   logic                       load;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;

   // gain correction: multiply, arithmetic shift, wrap to the datapath width
   assign gain_s = $signed({1'b0, gain});
   assign prod_x = PROD_W'(in_x) * PROD_W'(gain_s);
   assign prod_y = PROD_W'(in_y) * PROD_W'(gain_s);
   assign sh_x   = prod_x >>> FRAC_BITS;
   assign sh_y   = prod_y >>> FRAC_BITS;
   assign wrap_x = $signed(sh_x[WIDTH-1:0]);
   assign wrap_y = $signed(sh_y[WIDTH-1:0]);
   assign mag_in = OUT_W'(wrap_x);
   assign res_in = OUT_W'(wrap_y);

   always_comb begin
      if (in_ready) begin
         valid_in = in_valid;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (load) begin
         angle_ff <= in_angle;
         mag_ff   <= mag_in;
         res_ff   <= res_in;
      end
   end

   assign out_valid      = valid_ff;
   assign out_angle      = $signed(angle_ff);
   assign out_magnitude  = mag_ff;
   assign out_residual_y = res_ff;

endmodule

// File: design/cordic_vectoring_angle_magnitude.sv
// CORDIC vectoring: angle and gain-corrected magnitude of a fixed-point vector.
// Input channel req_*: a transaction carries vec_x and vec_y (signed, 8 fraction
// bits). Result channel rsp_*: one transaction per input with the angle, the
// magnitude (final x times gain) and the residual y (final y times gain).
// csr_write_enable/csr_write_data load the 8-bit gain register at once; write it
// only while no transaction is in flight.
// The datapath is a chain of 2*(FRAC_BITS+1) rotation cells, one register each,
// followed by one multiply stage that also acts as the output register.
// A transaction passes through the rotation cells in order and then the multiply
// stage. Every cell holds one transaction, so a new vector is accepted every
// cycle and throughput is one per cycle while rsp_ready is high.
// When the receiver stalls, the output stage holds its result and the chain
// keeps filling empty cells; req_ready drops only once every stage is occupied.
// Reset (synchronous, active high) empties all stages and sets gain to 78.
module cordic_vectoring_angle_magnitude #(
   parameter int unsigned WIDTH     = cvam_pkg::DEFAULT_WIDTH,
   parameter int unsigned FRAC_BITS = cvam_pkg::DEFAULT_FRAC_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [cvam_pkg::IN_W-1:0]    req_vec_x,
   input  logic signed [cvam_pkg::IN_W-1:0]    req_vec_y,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [cvam_pkg::ANGLE_W-1:0] rsp_angle,
   output logic signed [cvam_pkg::OUT_W-1:0]   rsp_magnitude,
   output logic signed [cvam_pkg::OUT_W-1:0]   rsp_residual_y,
   input  logic                                csr_write_enable,
   input  logic [cvam_pkg::GAIN_W-1:0]         csr_write_data
);
   import cvam_pkg::*;

   localparam int unsigned NUM_CELLS = REPEATS * (FRAC_BITS + 1);

   logic [GAIN_W-1:0]        gain_ff;
   logic                     c_valid [NUM_CELLS+1];
   logic                     c_ready [NUM_CELLS+1];
   logic signed [WIDTH-1:0]  c_x     [NUM_CELLS+1];
   logic signed [WIDTH-1:0]  c_y     [NUM_CELLS+1];
   logic [ANGLE_W-1:0]       c_angle [NUM_CELLS+1];

   // gain register
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= GAIN_RESET;
      end else if (csr_write_enable) begin
         gain_ff <= csr_write_data;
      end
   end

   // chain input: wrap the vector to the datapath width
   assign c_valid[0] = req_valid;
   assign req_ready  = c_ready[0];
   assign c_x[0]     = WIDTH'(req_vec_x);
   assign c_y[0]     = WIDTH'(req_vec_y);
   assign c_angle[0] = '0;

   // rotation cells, each shift used REPEATS times
   for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
      localparam int unsigned SHIFT = k / REPEATS;
      cvam_cell #(
         .WIDTH     (WIDTH),
         .FRAC_BITS (FRAC_BITS),
         .SHIFT     (SHIFT)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (c_valid[k]),
         .in_ready  (c_ready[k]),
         .in_x      (c_x[k]),
         .in_y      (c_y[k]),
         .in_angle  (c_angle[k]),
         .out_valid (c_valid[k+1]),
         .out_ready (c_ready[k+1]),
         .out_x     (c_x[k+1]),
         .out_y     (c_y[k+1]),
         .out_angle (c_angle[k+1])
      );
   end

   // gain correction and output register
   cvam_scale #(
      .WIDTH     (WIDTH),
      .FRAC_BITS (FRAC_BITS)
   ) u_scale (
      .clock          (clock),
      .reset          (reset),
      .gain           (gain_ff),
      .in_valid       (c_valid[NUM_CELLS]),
      .in_ready       (c_ready[NUM_CELLS]),
      .in_x           (c_x[NUM_CELLS]),
      .in_y           (c_y[NUM_CELLS]),
      .in_angle       (c_angle[NUM_CELLS]),
      .out_valid      (rsp_valid),
      .out_ready      (rsp_ready),
      .out_angle      (rsp_angle),
      .out_magnitude  (rsp_magnitude),
      .out_residual_y (rsp_residual_y)
   );

   // reset empties the output stage
   a_reset_empty : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // back-pressure at the input only comes from a stalled, full output
   a_stall_source : assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("input stalled without output stall");

   // a finished rotation entering the output stage shows up as a result
   a_last_cell_moves : assert property (@(posedge clock) disable iff (reset)
      (c_valid[NUM_CELLS] && c_ready[NUM_CELLS]) |=> rsp_valid)
      else $error("transaction lost between chain and output");

   // gain register follows a write
   a_gain_write : assert property (@(posedge clock) disable iff (reset)
      csr_write_enable |=> (gain_ff == $past(csr_write_data)))
      else $error("gain register not updated");

endmodule
